// ===== design/ibh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibh_pkg
// Types and codes shared by the indexed binary heap controller and datapath.
// ----------------------------------------------------------------------------
package ibh_pkg;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_LOAD      = 4'd1,  // capture the item, look up its position
    OP_DECIDE    = 4'd2,  // classify the item, read root / its current slot
    OP_RD_KIDS   = 4'd3,  // read both children of the hole
    OP_DOWN_CMP  = 4'd4,  // compare, maybe move a child up
    OP_RD_PARENT = 4'd5,  // read the parent of the hole
    OP_UP_CMP    = 4'd6,  // compare, maybe move the parent down
    OP_PLACE     = 4'd7,  // write the item into the hole
    OP_RD_LAST   = 4'd8   // read the last slot for a remove
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic no_work;   // item finishes right after DECIDE
    logic is_insert_new;
    logic down_done;
    logic up_done;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== design/ibh_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibh_datapath
// Slot memories, position table and the sift arithmetic of the heap.
// ----------------------------------------------------------------------------
module ibh_datapath #(
  parameter int CAPACITY = 64,
  parameter int KEY_WIDTH = 32,
  parameter int PAYLOAD_WIDTH = 32,
  parameter int ID_COUNT = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic max_order,
  input  wire ibh_pkg::dp_cmd_t cmd,
  output ibh_pkg::dp_stat_t stat,
  input  wire logic [1:0] in_action,
  input  wire logic [5:0] in_id,
  input  wire logic [31:0] in_key,
  input  wire logic [31:0] in_payload,
  output logic [1:0] res_status,
  output logic [31:0] res_root_payload,
  output logic [5:0] res_root_id,
  output logic [31:0] res_root_key,
  output logic [6:0] res_final_position,
  output logic [6:0] res_entry_count
);
  import ibh_pkg::*;

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int EW = KEY_WIDTH + PAYLOAD_WIDTH + IW;
  localparam int SW = PW + 1;

  // Slot memory holds key, payload and id together; slot 0 unused.
  logic [EW-1:0] slots [0:CAPACITY];
  logic [PW-1:0] id_pos [0:ID_COUNT-1];
  logic [ID_COUNT-1:0] pos_valid;

  logic [PW-1:0] occupancy;
  logic [1:0] action;
  logic [IW-1:0] id;
  logic id_oob;
  logic signed [KEY_WIDTH-1:0] key;
  logic [PAYLOAD_WIDTH-1:0] payload;
  logic [PW-1:0] hole;
  logic [EW-1:0] rd_a, rd_b;
  logic right_ok;
  logic [1:0] status;
  logic [PW-1:0] id_pos_rd;
  logic pos_valid_rd;

  // Memory ports: two registered reads, one write.
  logic [PW-1:0] ra_addr, rb_addr, w_addr;
  logic [EW-1:0] w_data;
  logic w_en;
  logic pw_en;
  logic [IW-1:0] pw_id;
  logic [PW-1:0] pw_pos;

  logic signed [KEY_WIDTH-1:0] ka, kb, kc;
  logic [EW-1:0] cand;
  logic [PW-1:0] cand_pos;
  logic [SW-1:0] left_s;
  logic [PW-1:0] left_p;
  logic [IW-1:0] cand_id;
  logic [PW-1:0] cur_lookup;
  logic exists;
  logic removing;
  logic grab_last, grab_upd;

  function automatic logic above(input logic mo, input logic signed [KEY_WIDTH-1:0] a,
                                 input logic signed [KEY_WIDTH-1:0] b);
    above = mo ? (a > b) : (a < b);
  endfunction

  assign ka = rd_a[EW-1 -: KEY_WIDTH];
  assign kb = rd_b[EW-1 -: KEY_WIDTH];
  assign left_s = {hole, 1'b0};
  assign left_p = left_s[PW-1:0];
  always_comb begin
    if (right_ok && !above(max_order, ka, kb)) begin
      cand = rd_b;
      cand_pos = left_p + PW'(1);
    end else begin
      cand = rd_a;
      cand_pos = left_p;
    end
  end
  assign kc = cand[EW-1 -: KEY_WIDTH];
  assign cand_id = cand[IW-1:0];
  assign cur_lookup = pos_valid_rd ? id_pos_rd : '0;

  assign exists = !id_oob && cur_lookup != '0 && cur_lookup <= occupancy;

  always_comb begin
    stat.no_work = 1'b0;
    stat.is_insert_new = 1'b0;
    case (action)
      ACT_INSERT: begin
        stat.no_work = id_oob || (!exists && occupancy >= PW'(CAPACITY));
        stat.is_insert_new = !exists;
      end
      ACT_REMOVE: stat.no_work = (occupancy == '0);
      ACT_UPDATE: stat.no_work = !exists;
      default:    stat.no_work = 1'b1;
    endcase
    stat.down_done = (SW'(left_p) != left_s) || left_p > occupancy
                     || !above(max_order, kc, key);
    stat.up_done = (hole <= PW'(1)) || !above(max_order, key, ka);
  end

  always_comb begin
    ra_addr = '0;
    rb_addr = '0;
    w_en = 1'b0;
    w_addr = hole;
    w_data = '0;
    pw_en = 1'b0;
    pw_id = id;
    pw_pos = hole;
    case (cmd.op)
      OP_DECIDE: begin
        ra_addr = PW'(1);
        rb_addr = cur_lookup;
      end
      OP_RD_LAST: begin
        // The removed root leaves the heap.
        rb_addr = occupancy + PW'(1);
        pw_en = 1'b1;
        pw_id = rd_a[IW-1:0];
        pw_pos = '0;
      end
      OP_RD_KIDS: begin
        ra_addr = left_p;
        rb_addr = left_p + PW'(1);
      end
      OP_DOWN_CMP: if (!stat.down_done) begin
        w_en = 1'b1;
        w_data = cand;
        pw_en = 1'b1;
        pw_id = cand_id;
      end
      OP_RD_PARENT: ra_addr = hole >> 1;
      OP_UP_CMP: if (!stat.up_done) begin
        w_en = 1'b1;
        w_data = rd_a;
        pw_en = 1'b1;
        pw_id = rd_a[IW-1:0];
      end
      // A remove that empties the heap has nothing to put back.
      OP_PLACE: if (!(removing && occupancy == '0)) begin
        w_en = 1'b1;
        w_data = {key, payload, id};
        pw_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_a <= slots[ra_addr];
    rd_b <= slots[rb_addr];
    if (w_en) begin
      slots[w_addr] <= w_data;
    end
    if (pw_en) begin
      id_pos[pw_id] <= pw_pos;
    end
    if (cmd.op == OP_LOAD) begin
      id_pos_rd <= id_pos[IW'(in_id)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_valid <= '0;
      pos_valid_rd <= 1'b0;
    end else begin
      if (pw_en) begin
        pos_valid[pw_id] <= 1'b1;
      end
      if (cmd.op == OP_LOAD) begin
        pos_valid_rd <= pos_valid[IW'(in_id)];
      end
    end
  end

  // Occupancy and item registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      removing <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: removing <= 1'b0;
        OP_DECIDE: if (!stat.no_work) begin
          if (action == ACT_REMOVE) begin
            occupancy <= occupancy - PW'(1);
            removing <= 1'b1;
          end else if (action == ACT_INSERT && !exists) begin
            occupancy <= occupancy + PW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Capture of last-slot entry (remove) and stored payload (update).
  always_ff @(posedge clk) begin
    if (rst) begin
      grab_last <= 1'b0;
      grab_upd <= 1'b0;
    end else begin
      grab_last <= (cmd.op == OP_RD_LAST);
      grab_upd <= (cmd.op == OP_DECIDE) && action == ACT_UPDATE && exists;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        action <= in_action;
        id <= IW'(in_id);
        id_oob <= (32'(in_id) >= ID_COUNT);
        key <= KEY_WIDTH'($signed(in_key));
        payload <= PAYLOAD_WIDTH'(in_payload);
        right_ok <= 1'b0;
      end
      OP_DECIDE: begin
        status <= ST_OK;
        res_root_payload <= '0;
        res_root_id <= '0;
        res_root_key <= '0;
        res_final_position <= '0;
        case (action)
          ACT_INSERT: begin
            if (id_oob) status <= ST_ABSENT;
            else if (!exists && occupancy >= PW'(CAPACITY)) status <= ST_FULL;
            hole <= exists ? cur_lookup : occupancy + PW'(1);
          end
          ACT_REMOVE: begin
            if (occupancy == '0) status <= ST_EMPTY;
            hole <= PW'(1);
          end
          ACT_UPDATE: begin
            if (!exists) status <= ST_ABSENT;
            hole <= cur_lookup;
          end
          default: ;
        endcase
      end
      OP_RD_LAST: begin
        // rd_a holds the root now.
        res_root_key <= 32'($signed(ka));
        res_root_payload <= 32'(rd_a[IW +: PAYLOAD_WIDTH]);
        res_root_id <= 6'(rd_a[IW-1:0]);
      end
      OP_RD_KIDS: begin
        right_ok <= (left_p + PW'(1)) <= occupancy && left_s[SW-1] == 1'b0;
      end
      OP_DOWN_CMP: if (!stat.down_done) hole <= cand_pos;
      OP_UP_CMP: if (!stat.up_done) hole <= hole >> 1;
      OP_PLACE: res_final_position <= removing ? 7'd0 : 7'(hole);
      default: ;
    endcase
    if (grab_last) begin
      key <= kb;
      payload <= rd_b[IW +: PAYLOAD_WIDTH];
      id <= rd_b[IW-1:0];
    end
    // An update keeps the payload already stored in its slot.
    if (grab_upd) begin
      payload <= rd_b[IW +: PAYLOAD_WIDTH];
    end
  end

  assign res_status = status;
  assign res_entry_count = 7'(occupancy);
endmodule
`default_nettype wire

// ===== design/ibh_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ibh_controller
// Sequences the heap operations and runs the item handshakes.
// ----------------------------------------------------------------------------
module ibh_controller (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic is_remove,
  input  wire ibh_pkg::dp_stat_t stat,
  output ibh_pkg::dp_cmd_t cmd,
  output logic busy,
  output logic out_valid,
  input  wire logic out_stall
);
  import ibh_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DECIDE = 11'b00000000010,
    S_RLAST  = 11'b00000000100,
    S_WAIT   = 11'b00000001000,
    S_KIDS   = 11'b00000010000,
    S_DCMP   = 11'b00000100000,
    S_PAR    = 11'b00001000000,
    S_UCMP   = 11'b00010000000,
    S_PLACE  = 11'b00100000000,
    S_OUT    = 11'b01000000000,
    S_PAD    = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic remove_q;

  always_comb begin
    state_next = state;
    cmd.op = OP_NONE;
    case (state)
      S_IDLE: if (in_fire) begin
        cmd.op = OP_LOAD;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.op = OP_DECIDE;
        if (stat.no_work) state_next = S_OUT;
        else if (is_remove) state_next = S_RLAST;
        else if (stat.is_insert_new) state_next = S_PAR;
        else state_next = S_WAIT;
      end
      S_RLAST: begin
        cmd.op = OP_RD_LAST;
        state_next = S_WAIT;
      end
      S_WAIT: state_next = S_PAD;
      S_PAD: state_next = S_KIDS;
      S_KIDS: begin
        cmd.op = OP_RD_KIDS;
        state_next = S_DCMP;
      end
      S_DCMP: begin
        cmd.op = OP_DOWN_CMP;
        if (stat.down_done) state_next = remove_q ? S_PLACE : S_PAR;
        else state_next = S_KIDS;
      end
      S_PAR: begin
        cmd.op = OP_RD_PARENT;
        state_next = S_UCMP;
      end
      S_UCMP: begin
        cmd.op = OP_UP_CMP;
        state_next = stat.up_done ? S_PLACE : S_PAR;
      end
      S_PLACE: begin
        cmd.op = OP_PLACE;
        state_next = S_OUT;
      end
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      remove_q <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DECIDE) remove_q <= is_remove;
    end
  end

  assign busy = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
endmodule
`default_nettype wire

// ===== design/indexed_binary_heap_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_binary_heap_unit
// Indexed binary heap priority queue with insert, remove-root and update.
// ----------------------------------------------------------------------------
// Usage:
// An item (action, entry_id, key, payload) is taken when in_valid is high and
// in_stall is low; in_stall stays high while an item is in work. One result
// per item appears with out_valid and is held until out_stall is low.
// After acceptance the item is classified; one that changes nothing goes
// straight to its result, a new insert sifts up, a remove reads the last slot
// and sifts down, and an update or a repeated insert sifts down and then up;
// each level the sift walks is one slot read followed by one compare and
// write. The next item is taken only after the result leaves, so the block
// never takes a new item before it is through with the last one.
// A stalled result holds the block; no new item enters.
// Reset clears the position table and the occupancy; slot data is only read
// below the occupancy. max_order is to be written through cfg_we / cfg_data
// only while idle, unchecked by the block: 0 gives a min-heap, 1 a max-heap.
// ----------------------------------------------------------------------------
module indexed_binary_heap_unit #(
  parameter int CAPACITY = 64,
  parameter int KEY_WIDTH = 32,
  parameter int PAYLOAD_WIDTH = 32,
  parameter int ID_COUNT = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_data,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [1:0] action,
  input  wire logic [5:0] entry_id,
  input  wire logic [31:0] key,
  input  wire logic [31:0] payload,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [1:0] status,
  output logic [31:0] root_payload,
  output logic [5:0] root_id,
  output logic [31:0] root_key,
  output logic [6:0] final_position,
  output logic [6:0] entry_count
);
  import ibh_pkg::*;

  logic max_order;
  logic busy;
  logic in_fire;
  logic action_q_remove;
  dp_cmd_t cmd;
  dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) max_order <= 1'b0;
    else if (cfg_we) max_order <= cfg_data;
  end

  assign in_stall = busy;
  assign in_fire = in_valid && !busy;

  ibh_controller u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .is_remove(action_q_remove),
    .stat(stat), .cmd(cmd), .busy(busy), .out_valid(out_valid),
    .out_stall(out_stall)
  );

  always_ff @(posedge clk) begin
    if (in_fire) action_q_remove <= (action == ACT_REMOVE);
  end

  ibh_datapath #(
    .CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH),
    .PAYLOAD_WIDTH(PAYLOAD_WIDTH), .ID_COUNT(ID_COUNT)
  ) u_dp (
    .clk(clk), .rst(rst), .max_order(max_order), .cmd(cmd), .stat(stat),
    .in_action(action), .in_id(entry_id), .in_key(key), .in_payload(payload),
    .res_status(status), .res_root_payload(root_payload), .res_root_id(root_id),
    .res_root_key(root_key), .res_final_position(final_position),
    .res_entry_count(entry_count)
  );

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("item accepted while a result is pending");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= 7'(CAPACITY)) else $error("occupancy beyond capacity");
  a_full_keeps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> entry_count == 7'(CAPACITY))
    else $error("full status with room left");
`endif
endmodule
`default_nettype wire
